// ----- rtl/core/affine_global_motion_fit_core_defines.svh -----
// Assertion macros for the affine global motion fit core.
`ifndef AFFINE_GLOBAL_MOTION_FIT_CORE_DEFINES_SVH
`define AFFINE_GLOBAL_MOTION_FIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AGMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define AGMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/agmf_pkg.sv -----
// Shared types, widths and codes of the affine global motion fit core.
package agmf_pkg;

  localparam int unsigned MAX_DIM = 256;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM) + 1;
  localparam int unsigned POS_W   = $clog2(MAX_DIM);
  localparam int unsigned KL_W    = POS_W + 2;
  localparam int unsigned MV_W    = 16;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned SV_W    = 33;
  localparam int unsigned SP_W    = 25;
  localparam int unsigned SVP_W   = 41;
  localparam int unsigned SPP_W   = 32;
  localparam int unsigned MEAN_W  = 24;
  localparam int unsigned GAIN_W  = 32;
  localparam int unsigned C_W     = 64;

  localparam int unsigned ACC_W     = 96;
  localparam int unsigned MAC_A_W   = 64;
  localparam int unsigned MAC_B_W   = 32;
  localparam int unsigned MAC_CNT_W = $clog2(MAC_B_W);
  localparam int unsigned DIV_N_W   = 96;
  localparam int unsigned DIV_D_W   = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] DIM_MIN   = 9'd3;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd64;

  typedef logic [1:0] stat_t;
  localparam stat_t STAT_OK       = 2'd0;
  localparam stat_t STAT_EMPTY    = 2'd1;
  localparam stat_t STAT_ZERO_DET = 2'd2;

  typedef struct packed {
    logic signed [MV_W-1:0] mv_x;
    logic signed [MV_W-1:0] mv_y;
    logic                   is_intra;
  } in_beat_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_x;
    logic signed [MEAN_W-1:0] mean_y;
    logic signed [GAIN_W-1:0] gain_xx;
    logic signed [GAIN_W-1:0] gain_xy;
    logic signed [GAIN_W-1:0] gain_yx;
    logic signed [GAIN_W-1:0] gain_yy;
    stat_t                    status;
  } out_beat_t;

  // acc = init +/- a*b
  typedef struct packed {
    logic signed [ACC_W-1:0]   init;
    logic signed [MAC_A_W-1:0] a;
    logic signed [MAC_B_W-1:0] b;
    logic                      sub;
  } mac_req_t;

  typedef struct packed {
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

endpackage

// ----- rtl/core/affine_global_motion_fit_core.sv -----
// Top level: least-squares affine global motion fit over a vector field.
//
//  channel | dir | handshake          | beat
//  --------+-----+--------------------+-------------------------------------
//  in_     | in  | in_valid/in_stall  | mv_x, mv_y, is_intra (one vector)
//  out_    | out | out_valid/out_stall| mean_x/y, four gains, status (field)
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata (W, H)
//
// Skipped vectors (border or intra) take only the accept cycle; used vectors take
// the accept cycle plus seven products through one 17x10 multiplier.
// End of field: the fit runs on the shared shift-add MAC (14 operations)
// and the 96-step restoring divider (6 divides).
// Reset is synchronous; no memory, so no clearing pass.
// A pending result may sit under out_stall while the next field streams in;
// the fit waits at its end only if that result is still not taken.
module affine_global_motion_fit_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  agmf_pkg::in_beat_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output agmf_pkg::out_beat_t              out_data,
  input  logic                             cfg_we,
  input  logic [agmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [agmf_pkg::DIM_W-1:0]       cfg_wdata
);
  import agmf_pkg::*;

`include "affine_global_motion_fit_core_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_ITEM, S_FIN_CHK, S_MEAN, S_MEAN_W, S_CTERM, S_CTERM_W,
    S_DET, S_DET_W, S_GMAC, S_GMAC_W, S_GDIV, S_GDIV_W, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    ST_VXK, ST_VYK, ST_VXL, ST_VYL, ST_KK, ST_LL, ST_KL
  } item_step_t;

  state_t     state_r;
  item_step_t step_r;
  logic [1:0] idx_r;
  logic       sub_r;

  // config and field accumulators
  logic [DIM_W-1:0]        fw_r, fh_r;
  logic [POS_W-1:0]        col_r, row_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [SV_W-1:0]  s_vx_r, s_vy_r;
  logic signed [SP_W-1:0]  s_k_r, s_l_r;
  logic signed [SVP_W-1:0] s_vxk_r, s_vyk_r, s_vxl_r, s_vyl_r;
  logic signed [SPP_W-1:0] s_kk_r, s_ll_r, s_kl_r;

  // latched vector and offsets of the item at work
  logic signed [MV_W-1:0]  vx_r, vy_r;
  logic signed [KL_W-1:0]  k_r, l_r;

  // fit results
  logic signed [MEAN_W-1:0] mx_r, my_r;
  logic signed [C_W-1:0]    cx_r, cxl_r, cy_r, cyl_r;
  logic [DIV_D_W-1:0]       det_r;
  logic signed [GAIN_W-1:0] g0_r, g1_r, g2_r, g3_r;
  stat_t                    stat_r;

  logic      out_valid_r;
  out_beat_t out_data_r;

  // position decode
  logic [DIM_W-1:0] w_eff, h_eff, w_m1, h_m1;
  logic             col_end, row_end, border_now, last_now, use_now, accept;
  logic [KL_W-1:0]  k_now, l_now;
  logic             clr_fld;

  always_comb begin
    w_eff = fw_r;
    if (fw_r < DIM_MIN) w_eff = DIM_MIN;
    else if (fw_r > DIM_W'(MAX_DIM)) w_eff = DIM_W'(MAX_DIM);
    h_eff = fh_r;
    if (fh_r < DIM_MIN) h_eff = DIM_MIN;
    else if (fh_r > DIM_W'(MAX_DIM)) h_eff = DIM_W'(MAX_DIM);
    w_m1       = w_eff - 1'b1;
    h_m1       = h_eff - 1'b1;
    col_end    = {1'b0, col_r} >= w_m1;
    row_end    = {1'b0, row_r} >= h_m1;
    border_now = (col_r == '0) || col_end || (row_r == '0) || row_end;
    last_now   = col_end && row_end;
    use_now    = !border_now && !in_data.is_intra;
    // offsets from the field centre
    k_now      = {2'b00, col_r} - {2'b00, w_eff[DIM_W-1:1]};
    l_now      = {2'b00, row_r} - {2'b00, h_eff[DIM_W-1:1]};
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign clr_fld  = (cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)) ||
                    (state_r == S_OUT && !out_valid_r);

  // per-item product unit
  logic signed [MV_W:0]           mul_a;
  logic signed [KL_W-1:0]         mul_b;
  logic signed [MV_W+KL_W:0]      mul_p;
  logic signed [SVP_W-1:0]        mul_p41;
  logic signed [SPP_W-1:0]        mul_p32;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      ST_VXK: begin mul_a = {vx_r[MV_W-1], vx_r}; mul_b = k_r; end
      ST_VYK: begin mul_a = {vy_r[MV_W-1], vy_r}; mul_b = k_r; end
      ST_VXL: begin mul_a = {vx_r[MV_W-1], vx_r}; mul_b = l_r; end
      ST_VYL: begin mul_a = {vy_r[MV_W-1], vy_r}; mul_b = l_r; end
      ST_KK:  begin mul_a = {{(MV_W+1-KL_W){k_r[KL_W-1]}}, k_r}; mul_b = k_r; end
      ST_LL:  begin mul_a = {{(MV_W+1-KL_W){l_r[KL_W-1]}}, l_r}; mul_b = l_r; end
      ST_KL:  begin mul_a = {{(MV_W+1-KL_W){k_r[KL_W-1]}}, k_r}; mul_b = l_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p   = mul_a * mul_b;
    mul_p41 = {{(SVP_W-MV_W-KL_W-1){mul_p[MV_W+KL_W]}}, mul_p};
    mul_p32 = {{(SPP_W-MV_W-KL_W-1){mul_p[MV_W+KL_W]}}, mul_p};
  end

  // accumulators, positions and config
  always_ff @(posedge clk) begin
    if (!rst_n || clr_fld) begin
      col_r   <= '0;
      row_r   <= '0;
      cnt_r   <= '0;
      s_vx_r  <= '0;
      s_vy_r  <= '0;
      s_k_r   <= '0;
      s_l_r   <= '0;
      s_vxk_r <= '0;
      s_vyk_r <= '0;
      s_vxl_r <= '0;
      s_vyl_r <= '0;
      s_kk_r  <= '0;
      s_ll_r  <= '0;
      s_kl_r  <= '0;
    end else if (accept) begin
      if (use_now) begin
        cnt_r  <= cnt_r + 1'b1;
        s_vx_r <= s_vx_r + {{(SV_W-MV_W){in_data.mv_x[MV_W-1]}}, in_data.mv_x};
        s_vy_r <= s_vy_r + {{(SV_W-MV_W){in_data.mv_y[MV_W-1]}}, in_data.mv_y};
        s_k_r  <= s_k_r + {{(SP_W-KL_W){k_now[KL_W-1]}}, k_now};
        s_l_r  <= s_l_r + {{(SP_W-KL_W){l_now[KL_W-1]}}, l_now};
      end
      if (col_end) begin
        col_r <= '0;
        row_r <= last_now ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end else if (state_r == S_ITEM) begin
      unique case (step_r)
        ST_VXK: s_vxk_r <= s_vxk_r + mul_p41;
        ST_VYK: s_vyk_r <= s_vyk_r + mul_p41;
        ST_VXL: s_vxl_r <= s_vxl_r + mul_p41;
        ST_VYL: s_vyl_r <= s_vyl_r + mul_p41;
        ST_KK:  s_kk_r  <= s_kk_r + mul_p32;
        ST_LL:  s_ll_r  <= s_ll_r + mul_p32;
        ST_KL:  s_kl_r  <= s_kl_r + mul_p32;
        default: s_kl_r <= s_kl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= DIM_RESET;
      fh_r <= DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH)  fw_r <= cfg_wdata;
      if (cfg_index == CFG_HEIGHT) fh_r <= cfg_wdata;
    end
  end

  // shared MAC and divider
  mac_req_t                mac_req;
  logic                    mac_start, mac_busy, mac_done;
  logic signed [ACC_W-1:0] mac_acc;
  div_req_t                div_req;
  logic                    div_start, div_busy, div_done;
  logic [DIV_N_W-1:0]      div_q;
  logic [DIV_D_W-1:0]      div_r;

  agmf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .req   (mac_req),
    .busy  (mac_busy),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  agmf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_r)
  );

  logic signed [SVP_W-1:0]  ct_s;
  logic signed [MEAN_W-1:0] ct_m;
  logic signed [SP_W-1:0]   ct_p;
  logic signed [C_W-1:0]    c_own, c_cross;
  logic signed [SPP_W-1:0]  s_other;
  logic signed [SV_W-1:0]   mean_s;
  logic [SV_W-1:0]          mean_mag;
  logic                     mean_neg;
  logic [MEAN_W-1:0]        mean_val;
  logic signed [ACC_W-1:0]  num_g;
  logic                     g_neg;
  logic [DIV_N_W-1:0]       g_mag;
  logic                     g_rnd;
  logic [DIV_N_W:0]         q_rnd, q_lim, q_sat;
  logic [GAIN_W-1:0]        g_val;
  logic                     det_bad;

  always_comb begin
    unique case (idx_r)
      2'd0: begin ct_s = s_vxk_r; c_own = cx_r;  c_cross = cxl_r; end
      2'd1: begin ct_s = s_vxl_r; c_own = cxl_r; c_cross = cx_r;  end
      2'd2: begin ct_s = s_vyk_r; c_own = cy_r;  c_cross = cyl_r; end
      2'd3: begin ct_s = s_vyl_r; c_own = cyl_r; c_cross = cy_r;  end
      default: begin ct_s = s_vxk_r; c_own = cx_r; c_cross = cxl_r; end
    endcase
    ct_m    = idx_r[1] ? my_r : mx_r;
    ct_p    = idx_r[0] ? s_l_r : s_k_r;
    s_other = idx_r[0] ? s_kk_r : s_ll_r;

    // mean: (|s|*256 + n/2) / n
    mean_s   = idx_r[0] ? s_vy_r : s_vx_r;
    mean_neg = mean_s[SV_W-1];
    mean_mag = mean_neg ? SV_W'(-mean_s) : SV_W'(mean_s);
    mean_val = mean_neg ? MEAN_W'(-div_q[MEAN_W-1:0]) : div_q[MEAN_W-1:0];

    // gain: round(256*num / det), ties away, saturated
    num_g = mac_acc <<< 8;
    g_neg = num_g[ACC_W-1];
    g_mag = g_neg ? DIV_N_W'(-num_g) : DIV_N_W'(num_g);
    g_rnd = {div_r, 1'b0} >= {1'b0, det_r};
    q_rnd = {1'b0, div_q} + (DIV_N_W+1)'(g_rnd);
    q_lim = g_neg ? (DIV_N_W+1)'(33'h0_8000_0000) : (DIV_N_W+1)'(33'h0_7FFF_FFFF);
    q_sat = (q_rnd > q_lim) ? q_lim : q_rnd;
    g_val = g_neg ? GAIN_W'(-q_sat[GAIN_W-1:0]) : q_sat[GAIN_W-1:0];

    det_bad = mac_acc[ACC_W-1] || (mac_acc == '0);

    mac_req   = '0;
    mac_start = 1'b0;
    div_req   = '0;
    div_start = 1'b0;
    unique case (state_r)
      S_MEAN: begin
        div_start   = 1'b1;
        div_req.num = DIV_N_W'({mean_mag, 8'h00}) + DIV_N_W'(cnt_r >> 1);
        div_req.den = DIV_D_W'(cnt_r);
      end
      S_CTERM: begin
        mac_start    = 1'b1;
        mac_req.init = {{(ACC_W-SVP_W-8){ct_s[SVP_W-1]}}, ct_s, 8'h00};
        mac_req.a    = {{(MAC_A_W-MEAN_W){ct_m[MEAN_W-1]}}, ct_m};
        mac_req.b    = {{(MAC_B_W-SP_W){ct_p[SP_W-1]}}, ct_p};
        mac_req.sub  = 1'b1;
      end
      S_DET: begin
        mac_start = 1'b1;
        if (!idx_r[0]) begin
          mac_req.init = '0;
          mac_req.a    = {{(MAC_A_W-SPP_W){s_kk_r[SPP_W-1]}}, s_kk_r};
          mac_req.b    = s_ll_r;
          mac_req.sub  = 1'b0;
        end else begin
          mac_req.init = mac_acc;
          mac_req.a    = {{(MAC_A_W-SPP_W){s_kl_r[SPP_W-1]}}, s_kl_r};
          mac_req.b    = s_kl_r;
          mac_req.sub  = 1'b1;
        end
      end
      S_GMAC: begin
        mac_start = 1'b1;
        if (!sub_r) begin
          mac_req.init = '0;
          mac_req.a    = c_own;
          mac_req.b    = s_other;
          mac_req.sub  = 1'b0;
        end else begin
          mac_req.init = mac_acc;
          mac_req.a    = c_cross;
          mac_req.b    = s_kl_r;
          mac_req.sub  = 1'b1;
        end
      end
      S_GDIV: begin
        div_start   = 1'b1;
        div_req.num = g_mag;
        div_req.den = det_r;
      end
      default: begin
        mac_start = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_VXK;
      idx_r       <= '0;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            vx_r <= in_data.mv_x;
            vy_r <= in_data.mv_y;
            k_r  <= k_now;
            l_r  <= l_now;
            if (use_now) begin
              step_r  <= ST_VXK;
              state_r <= S_ITEM;
            end else if (last_now) begin
              state_r <= S_FIN_CHK;
            end
          end
        end
        S_ITEM: begin
          if (step_r == ST_KL) state_r <= S_IDLE;
          else step_r <= item_step_t'(step_r + 1'b1);
        end
        S_FIN_CHK: begin
          idx_r <= '0;
          sub_r <= 1'b0;
          if (cnt_r == '0) begin
            mx_r    <= '0;
            my_r    <= '0;
            g0_r    <= '0;
            g1_r    <= '0;
            g2_r    <= '0;
            g3_r    <= '0;
            stat_r  <= STAT_EMPTY;
            state_r <= S_OUT;
          end else begin
            state_r <= S_MEAN;
          end
        end
        S_MEAN: state_r <= S_MEAN_W;
        S_MEAN_W: begin
          if (div_done) begin
            if (idx_r[0]) begin
              my_r    <= mean_val;
              idx_r   <= '0;
              state_r <= S_CTERM;
            end else begin
              mx_r    <= mean_val;
              idx_r   <= idx_r + 1'b1;
              state_r <= S_MEAN;
            end
          end
        end
        S_CTERM: state_r <= S_CTERM_W;
        S_CTERM_W: begin
          if (mac_done) begin
            unique case (idx_r)
              2'd0: cx_r  <= mac_acc[C_W-1:0];
              2'd1: cxl_r <= mac_acc[C_W-1:0];
              2'd2: cy_r  <= mac_acc[C_W-1:0];
              2'd3: cyl_r <= mac_acc[C_W-1:0];
              default: cx_r <= cx_r;
            endcase
            idx_r   <= idx_r + 1'b1;
            state_r <= (idx_r == 2'd3) ? S_DET : S_CTERM;
          end
        end
        S_DET: state_r <= S_DET_W;
        S_DET_W: begin
          if (mac_done) begin
            if (!idx_r[0]) begin
              idx_r   <= 2'd1;
              state_r <= S_DET;
            end else begin
              det_r <= mac_acc[DIV_D_W-1:0];
              idx_r <= '0;
              sub_r <= 1'b0;
              if (det_bad) begin
                g0_r    <= '0;
                g1_r    <= '0;
                g2_r    <= '0;
                g3_r    <= '0;
                stat_r  <= STAT_ZERO_DET;
                state_r <= S_OUT;
              end else begin
                stat_r  <= STAT_OK;
                state_r <= S_GMAC;
              end
            end
          end
        end
        S_GMAC: state_r <= S_GMAC_W;
        S_GMAC_W: begin
          if (mac_done) begin
            if (!sub_r) begin
              sub_r   <= 1'b1;
              state_r <= S_GMAC;
            end else begin
              state_r <= S_GDIV;
            end
          end
        end
        S_GDIV: state_r <= S_GDIV_W;
        S_GDIV_W: begin
          if (div_done) begin
            unique case (idx_r)
              2'd0: g0_r <= g_val;
              2'd1: g1_r <= g_val;
              2'd2: g2_r <= g_val;
              2'd3: g3_r <= g_val;
              default: g0_r <= g0_r;
            endcase
            sub_r   <= 1'b0;
            idx_r   <= idx_r + 1'b1;
            state_r <= (idx_r == 2'd3) ? S_OUT : S_GMAC;
          end
        end
        S_OUT: begin
          // wait for the previous field's beat to leave
          if (!out_valid_r) begin
            out_data_r.mean_x  <= mx_r;
            out_data_r.mean_y  <= my_r;
            out_data_r.gain_xx <= g0_r;
            out_data_r.gain_xy <= g1_r;
            out_data_r.gain_yx <= g2_r;
            out_data_r.gain_yy <= g3_r;
            out_data_r.status  <= stat_r;
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `AGMF_ASSERT_NOW(a_mac_free, mac_start, !mac_busy, "MAC started while busy")
  `AGMF_ASSERT_NOW(a_div_free, div_start, !div_busy, "divider started while busy")
  `AGMF_ASSERT_NOW(a_mac_done_ctx, mac_done, state_r == S_CTERM_W || state_r == S_DET_W || state_r == S_GMAC_W, "MAC done outside a wait state")
  `AGMF_ASSERT_NEXT(a_last_fit, accept && last_now, state_r == S_FIN_CHK, "field end did not start fit")
  `AGMF_ASSERT_NEXT(a_emit, state_r == S_OUT && !out_valid_r, out_valid_r && state_r == S_IDLE, "result not emitted")

endmodule

// ----- rtl/core/agmf_mac.sv -----
// Shift-add multiply-accumulate unit, one multiplier bit per cycle.
module agmf_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  agmf_pkg::mac_req_t                 req,
  output logic                               busy,
  output logic                               done,
  output logic signed [agmf_pkg::ACC_W-1:0]  acc
);
  import agmf_pkg::*;

  logic signed [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]          mcand_r;
  logic [MAC_B_W-1:0]        mplr_r;
  logic                      neg_r;
  logic [MAC_CNT_W-1:0]      cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [MAC_A_W-1:0]        a_mag;
  logic [MAC_B_W-1:0]        b_mag;
  logic [ACC_W-1:0]          addend;

  always_comb begin
    a_mag  = req.a[MAC_A_W-1] ? MAC_A_W'(-req.a) : MAC_A_W'(req.a);
    b_mag  = req.b[MAC_B_W-1] ? MAC_B_W'(-req.b) : MAC_B_W'(req.b);
    addend = neg_r ? -mcand_r : mcand_r;
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      acc_r   <= req.init;
      mcand_r <= ACC_W'(a_mag);
      mplr_r  <= b_mag;
      neg_r   <= req.a[MAC_A_W-1] ^ req.b[MAC_B_W-1] ^ req.sub;
      cnt_r   <= '0;
      busy_r  <= 1'b1;
    end else if (busy_r) begin
      if (mplr_r[0]) begin
        acc_r <= acc_r + $signed(addend);
      end
      mcand_r <= mcand_r << 1;
      mplr_r  <= mplr_r >> 1;
      cnt_r   <= cnt_r + 1'b1;
      if (cnt_r == MAC_CNT_W'(MAC_B_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign acc  = acc_r;

endmodule

// ----- rtl/core/agmf_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module agmf_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  agmf_pkg::div_req_t               req,
  output logic                             busy,
  output logic                             done,
  output logic [agmf_pkg::DIV_N_W-1:0]     quo,
  output logic [agmf_pkg::DIV_D_W-1:0]     rem
);
  import agmf_pkg::*;

  logic [DIV_N_W-1:0]   dvd_r;
  logic [DIV_N_W-1:0]   quo_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_D_W-1:0]   den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W:0]     diff;
  logic                 ge;

  always_comb begin
    shifted = {rem_r, dvd_r[DIV_N_W-1]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      dvd_r  <= req.num;
      den_r  <= req.den;
      rem_r  <= '0;
      quo_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
      quo_r <= {quo_r[DIV_N_W-2:0], ge};
      dvd_r <= dvd_r << 1;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ----- dv/tb_affine_global_motion_fit_core.sv -----
// Testbench for the affine global motion fit core: vector fields in, one fit per field out.
`timescale 1ns / 1ps

module tb_affine_global_motion_fit_core;
  import agmf_pkg::*;

  typedef logic signed [127:0] wide_t;

  // Register index that the block must ignore.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned TOTAL_ITEMS = 900;
  // Watchdog limit, well above the slowest correct run.
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 40;

  // Running least-squares sums for one field, plus the fits still owed by the block.
  class fit_scoreboard;
    logic [DIM_W-1:0] reg_w, reg_h;
    int col, row;
    longint cnt, svx, svy, sk, sl, svxk, svyk, svxl, svyl, skk, sll, skl;
    out_beat_t owed[$];
    int errors;

    function new();
      reg_w = DIM_RESET;
      reg_h = DIM_RESET;
      errors = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      col = 0; row = 0; cnt = 0;
      svx = 0; svy = 0; sk = 0; sl = 0;
      svxk = 0; svyk = 0; svxl = 0; svyl = 0;
      skk = 0; sll = 0; skl = 0;
    endfunction

    function int clamp_dim(logic [DIM_W-1:0] d);
      if (d < DIM_MIN) return DIM_MIN;
      if (d > MAX_DIM) return MAX_DIM;
      return d;
    endfunction

    function int eff_w();
      return clamp_dim(reg_w);
    endfunction

    function int eff_h();
      return clamp_dim(reg_h);
    endfunction

    // Any valid register write also restarts the field.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      if (idx == CFG_WIDTH) reg_w = val;
      else if (idx == CFG_HEIGHT) reg_h = val;
      else return;
      clear_sums();
    endfunction

    // Q.8 mean, ties away from zero.
    function longint mean_q8(longint s);
      longint mag, q;
      mag = (s < 0) ? -s : s;
      q = (mag * 256 + cnt / 2) / cnt;
      return (s < 0) ? -q : q;
    endfunction

    // Cramer numerator over det, Q16.16, rounded away from zero, saturated.
    function longint solve_gain(longint c_own, longint s_other, longint c_cross,
                                longint s_kl, wide_t det);
      wide_t num, mag, q, lim;
      num = (wide_t'(c_own) * wide_t'(s_other) - wide_t'(c_cross) * wide_t'(s_kl)) <<< 8;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + det) / (2 * det);
      lim = (num < 0) ? wide_t'(64'h80000000) : wide_t'(64'h7FFFFFFF);
      if (q > lim) q = lim;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function out_beat_t fit_field();
      out_beat_t r;
      longint mx, my, cx, cxl, cy, cyl;
      wide_t det;
      r = '0;
      if (cnt == 0) begin
        r.status = STAT_EMPTY;
        return r;
      end
      mx = mean_q8(svx);
      my = mean_q8(svy);
      cx  = 256 * svxk - mx * sk;
      cxl = 256 * svxl - mx * sl;
      cy  = 256 * svyk - my * sk;
      cyl = 256 * svyl - my * sl;
      det = wide_t'(skk) * wide_t'(sll) - wide_t'(skl) * wide_t'(skl);
      r.mean_x = mx[MEAN_W-1:0];
      r.mean_y = my[MEAN_W-1:0];
      if (det <= 0) begin
        r.status = STAT_ZERO_DET;
      end else begin
        r.status = STAT_OK;
        r.gain_xx = GAIN_W'(solve_gain(cx, sll, cxl, skl, det));
        r.gain_xy = GAIN_W'(solve_gain(cxl, skk, cx, skl, det));
        r.gain_yx = GAIN_W'(solve_gain(cy, sll, cyl, skl, det));
        r.gain_yy = GAIN_W'(solve_gain(cyl, skk, cy, skl, det));
      end
      return r;
    endfunction

    function void note_vector(in_beat_t v);
      int w, h;
      bit border, last;
      longint vx, vy, k, l;
      w = eff_w();
      h = eff_h();
      border = (col == 0) || (col >= w - 1) || (row == 0) || (row >= h - 1);
      last = (col >= w - 1) && (row >= h - 1);
      if (!border && !v.is_intra) begin
        vx = longint'(v.mv_x);
        vy = longint'(v.mv_y);
        k = col - (w >> 1);
        l = row - (h >> 1);
        cnt++;
        svx += vx; svy += vy; sk += k; sl += l;
        svxk += vx * k; svyk += vy * k; svxl += vx * l; svyl += vy * l;
        skk += k * k; sll += l * l; skl += k * l;
      end
      if (col >= w - 1) begin
        col = 0;
        row = last ? 0 : row + 1;
      end else begin
        col++;
      end
      if (last) begin
        owed.push_back(fit_field());
        clear_sums();
      end
    endfunction

    task report(string what, longint got, longint exp);
      $display("mismatch %s: got %0h expected %0h", what, got, exp);
      errors++;
    endtask

    task check_fit(out_beat_t got);
      out_beat_t e;
      if (owed.size() == 0) begin
        report("unexpected fit beat", got.status, 0);
        return;
      end
      e = owed.pop_front();
      if (got.mean_x !== e.mean_x) report("mean_x", got.mean_x, e.mean_x);
      if (got.mean_y !== e.mean_y) report("mean_y", got.mean_y, e.mean_y);
      if (got.gain_xx !== e.gain_xx) report("gain_xx", got.gain_xx, e.gain_xx);
      if (got.gain_xy !== e.gain_xy) report("gain_xy", got.gain_xy, e.gain_xy);
      if (got.gain_yx !== e.gain_yx) report("gain_yx", got.gain_yx, e.gain_yx);
      if (got.gain_yy !== e.gain_yy) report("gain_yy", got.gain_yy, e.gain_yy);
      if (got.status !== e.status) report("status", got.status, e.status);
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  in_beat_t in_data;
  out_beat_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_wdata;

  fit_scoreboard fits = new();
  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = 0;
  int stall_hold = 0;
  longint cycles = 0;

  affine_global_motion_fit_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL affine_global_motion_fit_core");
      $finish;
    end
  end

  // Result side: check every accepted beat, then pick the next stall value.
  // Stall modes: 0 never, 1 light, 2 heavy, 3 solid block for a while.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) fits.check_fit(out_data);
    if ($urandom_range(0, 63) == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(5, 40);
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        out_stall <= (stall_hold > 0);
        if (stall_hold > 0) stall_hold--;
      end
    endcase
  end

  // One vector beat; valid stays high within a burst and may drop for a random gap after it.
  task automatic send_vector(in_beat_t v);
    int gap;
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (in_stall);
    fits.note_vector(v);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending, drain owed fits, then let the last used vector finish.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fits.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    fits.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [MV_W-1:0] pick_mv(int mode, int a, int b, int c, int pos_k,
                                                     int pos_l);
    int v;
    case (mode)
      0: begin
        case ($urandom_range(0, 7))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          default: return $urandom();
        endcase
      end
      1: return $urandom_range(0, 128) - 64;
      default: begin
        // affine motion plus a little noise
        v = a * pos_k + b * pos_l + c + int'($urandom_range(0, 8)) - 4;
        return v[MV_W-1:0];
      end
    endcase
  endfunction

  // Drive n vectors of the current field starting at its origin.
  task automatic drive_field(int mode, int intra_pct, int n);
    int w, a, b, c, d, e, f;
    in_beat_t v;
    w = fits.eff_w();
    a = $urandom_range(0, 40) - 20; b = $urandom_range(0, 40) - 20;
    c = $urandom_range(0, 2000) - 1000;
    d = $urandom_range(0, 40) - 20; e = $urandom_range(0, 40) - 20;
    f = $urandom_range(0, 2000) - 1000;
    for (int i = 0; i < n; i++) begin
      v.mv_x = pick_mv(mode, a, b, c, i % w, i / w);
      v.mv_y = pick_mv(mode, d, e, f, i % w, i / w);
      v.is_intra = ($urandom_range(0, 99) < intra_pct);
      send_vector(v);
    end
  endtask

  task automatic full_field(int mode, int intra_pct);
    drive_field(mode, intra_pct, fits.eff_w() * fits.eff_h());
  endtask

  task automatic directed_field(in_beat_t center, bit all_intra);
    in_beat_t v;
    for (int i = 0; i < 9; i++) begin
      v = (i == 4) ? center : in_beat_t'({16'sh0, 16'sh0, 1'b0});
      if (all_intra) v.is_intra = 1'b1;
      send_vector(v);
    end
  endtask

  initial begin
    int r, span;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Width keeps its reset value: one 64x3 field.
    write_cfg(CFG_HEIGHT, 9'd3);
    full_field(1, 10);
    settle();

    // Smallest field: a single interior vector gives a zero determinant.
    write_cfg(CFG_WIDTH, 9'd3);
    directed_field('{mv_x: 16'sh8000, mv_y: 16'sh7FFF, is_intra: 1'b0}, 1'b0);
    directed_field('{mv_x: 16'sh7FFF, mv_y: 16'sh8000, is_intra: 1'b0}, 1'b0);
    // Everything intra: empty field.
    directed_field('{mv_x: 16'sh1234, mv_y: 16'sh4321, is_intra: 1'b1}, 1'b1);
    settle();
    // Out-of-range index must be ignored (field keeps going at 3x3).
    write_cfg(CFG_UNUSED, 9'd7);

    // Random fields of small size; now and then a new size or an aborted field.
    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        span = fits.eff_w() * fits.eff_h();
        drive_field($urandom_range(0, 2), 10, $urandom_range(1, span - 1));
        settle();
        write_cfg($urandom_range(0, 1) ? CFG_WIDTH : CFG_HEIGHT, $urandom_range(0, 9));
      end else if (r < 3) begin
        settle();
        if ($urandom_range(0, 4) == 0) write_cfg(CFG_UNUSED, $urandom_range(0, 511));
        write_cfg(CFG_WIDTH, $urandom_range(0, 9));
        write_cfg(CFG_HEIGHT, $urandom_range(0, 9));
      end
      full_field($urandom_range(0, 2),
                 ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(0, 30));
    end

    settle();
    repeat (100) @(posedge clk);
    if (fits.errors == 0 && fits.owed.size() == 0) begin
      $display("PASS affine_global_motion_fit_core");
    end else begin
      $display("FAIL affine_global_motion_fit_core");
    end
    $finish;
  end

endmodule
